FILE: hw/rtl/pcc_pkg.sv
// Shared types and constants for the PI current controller with PWM output.
`timescale 1ns / 1ps

package pcc_pkg;

    // Field widths
    localparam int CUR_W      = 16;
    localparam int DUTY_FRAC  = 15;
    localparam int DUTY_W     = DUTY_FRAC + 1;
    localparam int GAIN_FRAC  = 24;
    localparam int GAIN_W     = 20;
    localparam int LIMIT_W    = 17;
    localparam int PERIOD_W   = 16;
    localparam int INTEG_W    = 18;
    localparam int ERR_W      = CUR_W + 1;
    localparam int DUTY_SHIFT = GAIN_FRAC - DUTY_FRAC;

    // Shared multiplier operand and product widths
    localparam int MUL_A_W = GAIN_W + 1;
    localparam int MUL_B_W = INTEG_W;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    // Duty saturation bounds
    localparam logic signed [DUTY_W-1:0] DUTY_MAX = DUTY_W'((1 << DUTY_FRAC) - 1);
    localparam logic signed [DUTY_W-1:0] DUTY_NEG_FULL = {1'b1, {DUTY_FRAC{1'b0}}};

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    localparam logic [CFG_IDX_W-1:0] REG_TARGET   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OL_DUTY  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PROP     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INTEG    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD   = 3'd5;

    // Control modes carried in the input tuser
    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_OPEN = 2'd1,
        MODE_HOLD = 2'd2,
        MODE_TEST = 2'd3
    } t_mode;

    // Classified command between the front end and the back end
    typedef struct packed {
        logic                     is_pi;
        logic signed [ERR_W-1:0]  err;
        logic signed [DUTY_W-1:0] duty;
    } t_cmd;

    // Loop settings used by the back end
    typedef struct packed {
        logic [GAIN_W-1:0]   prop_gain;
        logic [GAIN_W-1:0]   integ_gain;
        logic [LIMIT_W-1:0]  integ_limit;
        logic [PERIOD_W-1:0] pwm_period;
    } t_cfg;

endpackage

FILE: hw/rtl/pcc_front.sv
// Front end: accepts control ticks and turns them into loop commands.
`timescale 1ns / 1ps

module pcc_front import pcc_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic [1:0]               i_mode,
    input  logic signed [CUR_W-1:0]  i_meas,
    input  logic signed [CUR_W-1:0]  i_test_target,
    input  logic signed [CUR_W-1:0]  i_target_current,
    input  logic signed [DUTY_W-1:0] i_open_loop_duty,
    input  logic                     i_full,
    output logic                     o_push,
    output t_cmd                     o_cmd
);

    t_mode                   w_mode;
    logic signed [CUR_W-1:0] w_tgt;

    // Take a tick whenever the queue has room
    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;
    assign w_mode  = t_mode'(i_mode);

    // Classify the tick: PI error for closed-loop modes, direct duty otherwise
    always_comb begin
        w_tgt = i_target_current;
        o_cmd = '0;
        unique case (w_mode)
            MODE_IDLE: begin
                o_cmd.duty = '0;
            end
            MODE_OPEN: begin
                o_cmd.duty = (i_open_loop_duty == DUTY_NEG_FULL) ? -DUTY_MAX
                                                                 : i_open_loop_duty;
            end
            MODE_HOLD, MODE_TEST: begin
                if (w_mode == MODE_TEST) begin
                    w_tgt = i_test_target;
                end
                o_cmd.is_pi = 1'b1;
                o_cmd.err   = {w_tgt[CUR_W-1], w_tgt} - {i_meas[CUR_W-1], i_meas};
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_push_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> (o_ready && i_valid))
        else $error("front pushed without room");
`endif

endmodule

FILE: hw/rtl/pcc_fifo.sv
// Two-entry command queue between the front end and the back end.
`timescale 1ns / 1ps

module pcc_fifo import pcc_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_data,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_cmd o_data
);

    t_cmd       r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_mem[r_rd_ptr];

    // Store pushed commands
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

FILE: hw/rtl/pcc_back.sv
// Back end: PI arithmetic on a shared multiplier and the registered result.
`timescale 1ns / 1ps

module pcc_back import pcc_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cfg                     i_cfg,
    input  logic                     i_cmd_valid,
    input  t_cmd                     i_cmd,
    output logic                     o_pop,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic [PERIOD_W-1:0]      o_cmp,
    output logic                     o_dir,
    output logic signed [DUTY_W-1:0] o_duty
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_INTP,
        S_SUM,
        S_CMP
    } t_state;

    t_state                     r_state, n_state;
    logic signed [INTEG_W-1:0]  r_integ, n_integ;
    logic signed [PROD_W-1:0]   r_prod_p, n_prod_p;
    logic signed [PROD_W-1:0]   r_prod_i, n_prod_i;
    logic signed [DUTY_W-1:0]   r_duty, n_duty;
    logic                       r_out_valid, n_out_valid;
    logic [PERIOD_W-1:0]        r_cmp, n_cmp;
    logic                       r_dir, n_dir;
    logic signed [DUTY_W-1:0]   r_duty_out, n_duty_out;

    logic signed [MUL_A_W-1:0]  w_mul_a;
    logic signed [MUL_B_W-1:0]  w_mul_b;
    logic signed [PROD_W-1:0]   w_prod;
    logic [DUTY_W-1:0]          w_mag;
    logic signed [INTEG_W:0]    w_isum;
    logic signed [INTEG_W:0]    w_lim;
    logic signed [INTEG_W-1:0]  w_integ_sat;
    logic signed [PROD_W-1:0]   w_acc;
    logic signed [PROD_W-1:0]   w_acc_sh;
    logic signed [DUTY_W-1:0]   w_duty_sat;

    // Magnitude of the duty, which never reaches negative full scale
    assign w_mag = r_duty[DUTY_W-1] ? DUTY_W'(-r_duty) : r_duty;

    // Select operands of the shared multiplier by step
    always_comb begin
        unique case (r_state)
            S_IDLE: begin
                w_mul_a = {1'b0, i_cfg.prop_gain};
                w_mul_b = MUL_B_W'(i_cmd.err);
            end
            S_INTP: begin
                w_mul_a = {1'b0, i_cfg.integ_gain};
                w_mul_b = r_integ;
            end
            S_CMP: begin
                w_mul_a = {{(MUL_A_W-PERIOD_W){1'b0}}, i_cfg.pwm_period};
                w_mul_b = {{(MUL_B_W-DUTY_FRAC){1'b0}}, w_mag[DUTY_FRAC-1:0]};
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_prod = w_mul_a * w_mul_b;

    // Integrate the error and clamp to the symmetric limit
    assign w_isum = {r_integ[INTEG_W-1], r_integ}
                  + (INTEG_W+1)'(i_cmd.err);
    assign w_lim  = {2'b00, i_cfg.integ_limit};

    always_comb begin
        if (w_isum > w_lim) begin
            w_integ_sat = INTEG_W'(w_lim);
        end else if (w_isum < -w_lim) begin
            w_integ_sat = INTEG_W'(-w_lim);
        end else begin
            w_integ_sat = INTEG_W'(w_isum);
        end
    end

    // Sum both terms, floor to duty scale and saturate
    assign w_acc    = r_prod_p + r_prod_i;
    assign w_acc_sh = w_acc >>> DUTY_SHIFT;

    always_comb begin
        if (w_acc_sh > PROD_W'(DUTY_MAX)) begin
            w_duty_sat = DUTY_MAX;
        end else if (w_acc_sh < -PROD_W'(DUTY_MAX)) begin
            w_duty_sat = -DUTY_MAX;
        end else begin
            w_duty_sat = w_acc_sh[DUTY_W-1:0];
        end
    end

    // Sequence one command through the steps
    always_comb begin
        n_state     = r_state;
        n_integ     = r_integ;
        n_prod_p    = r_prod_p;
        n_prod_i    = r_prod_i;
        n_duty      = r_duty;
        n_out_valid = r_out_valid;
        n_cmp       = r_cmp;
        n_dir       = r_dir;
        n_duty_out  = r_duty_out;
        o_pop       = 1'b0;

        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    o_pop = 1'b1;
                    if (i_cmd.is_pi) begin
                        n_integ  = w_integ_sat;
                        n_prod_p = w_prod;
                        n_state  = S_INTP;
                    end else begin
                        n_duty  = i_cmd.duty;
                        n_state = S_CMP;
                    end
                end
            end
            S_INTP: begin
                n_prod_i = w_prod;
                n_state  = S_SUM;
            end
            S_SUM: begin
                n_duty  = w_duty_sat;
                n_state = S_CMP;
            end
            S_CMP: begin
                if (!r_out_valid || i_ready) begin
                    n_out_valid = 1'b1;
                    n_cmp       = w_prod[DUTY_FRAC +: PERIOD_W];
                    n_dir       = !r_duty[DUTY_W-1];
                    n_duty_out  = r_duty;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold state, integrator and registered result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_integ     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_integ     <= n_integ;
            r_out_valid <= n_out_valid;
        end
        r_prod_p   <= n_prod_p;
        r_prod_i   <= n_prod_i;
        r_duty     <= n_duty;
        r_cmp      <= n_cmp;
        r_dir      <= n_dir;
        r_duty_out <= n_duty_out;
    end

    assign o_valid = r_out_valid;
    assign o_cmp   = r_cmp;
    assign o_dir   = r_dir;
    assign o_duty  = r_duty_out;

`ifndef SYNTHESIS
    a_duty_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CMP) |-> (r_duty != DUTY_NEG_FULL))
        else $error("duty reached negative full scale");
    a_valid_from_cmp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_CMP))
        else $error("result raised outside the compare step");
    a_dir_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_dir == !r_duty_out[DUTY_W-1]))
        else $error("direction disagrees with duty sign");
    a_zero_cmp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_duty_out == '0) |-> (r_cmp == '0))
        else $error("nonzero compare for zero duty");
`endif

endmodule

FILE: hw/rtl/pi_current_controller_pwm_core.sv
// Top level of the PI current controller: settings, front end, queue, back end.
`timescale 1ns / 1ps

// One control tick in, one PWM result out. Idle and open-loop ticks skip the back
// end's integral and sum steps; for hold and test ticks the single shared
// multiplier is used for the proportional product, the integral product and the
// period-times-duty compare, one after the other. A two-entry queue lets the front
// end take ticks while the back end works, and the back end waits in its final
// step only while an untaken result sits in the output register. Settings are
// written through a plain write port; writes to unused indexes are ignored.

module pi_current_controller_pwm_core import pcc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Settings write port
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // Control tick input
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [31:0]           s_axis_tdata,  // [15:0] sensed_current, [31:16] test_target
    input  logic [1:0]            s_axis_tuser,  // [1:0] mode
    // PWM result output
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [39:0]           m_axis_tdata   // [15:0] compare_value, [16] direction,
                                                 // [32:17] duty_out, [39:33] zero
);

    logic signed [CUR_W-1:0]  r_target_current;
    logic signed [DUTY_W-1:0] r_open_loop_duty;
    t_cfg                     r_cfg;

    logic                     w_push;
    logic                     w_full;
    t_cmd                     w_cmd_in;
    logic                     w_cmd_valid;
    t_cmd                     w_cmd_out;
    logic                     w_pop;
    logic [PERIOD_W-1:0]      w_cmp;
    logic                     w_dir;
    logic signed [DUTY_W-1:0] w_duty;

    // Write settings
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_current       <= '0;
            r_open_loop_duty       <= '0;
            r_cfg.prop_gain        <= GAIN_W'(26844);
            r_cfg.integ_gain       <= GAIN_W'(6711);
            r_cfg.integ_limit      <= LIMIT_W'(2000);
            r_cfg.pwm_period       <= PERIOD_W'(1199);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_TARGET:  r_target_current  <= i_cfg_data[CUR_W-1:0];
                REG_OL_DUTY: r_open_loop_duty  <= i_cfg_data[DUTY_W-1:0];
                REG_PROP:    r_cfg.prop_gain   <= i_cfg_data[GAIN_W-1:0];
                REG_INTEG:   r_cfg.integ_gain  <= i_cfg_data[GAIN_W-1:0];
                REG_LIMIT:   r_cfg.integ_limit <= i_cfg_data[LIMIT_W-1:0];
                REG_PERIOD:  r_cfg.pwm_period  <= i_cfg_data[PERIOD_W-1:0];
                default: begin
                end
            endcase
        end
    end

    pcc_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (s_axis_tvalid),
        .o_ready          (s_axis_tready),
        .i_mode           (s_axis_tuser),
        .i_meas           (s_axis_tdata[15:0]),
        .i_test_target    (s_axis_tdata[31:16]),
        .i_target_current (r_target_current),
        .i_open_loop_duty (r_open_loop_duty),
        .i_full           (w_full),
        .o_push           (w_push),
        .o_cmd            (w_cmd_in)
    );

    pcc_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_cmd_in),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_cmd_valid),
        .o_data  (w_cmd_out)
    );

    pcc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd       (w_cmd_out),
        .o_pop       (w_pop),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_cmp       (w_cmp),
        .o_dir       (w_dir),
        .o_duty      (w_duty)
    );

    // Pack the result
    assign m_axis_tdata = {7'd0, w_duty, w_dir, w_cmp};

endmodule
